FILE: design/bvl_pkg.sv
// ----------------------------------------------------------------------------
// bvl_pkg
// Shared constants, codes, state type and helpers for the brickmap lookup.
// ----------------------------------------------------------------------------
package bvl_pkg;

    localparam int HEADER_DEPTH = 4096;
    localparam int HEAP_BRICKS  = 16;
    localparam int BRICK_EDGE   = 8;
    localparam int BRICK_VOXELS = BRICK_EDGE * BRICK_EDGE * BRICK_EDGE;
    localparam int HEAP_WORDS   = HEAP_BRICKS * BRICK_VOXELS;

    localparam int HDR_AW  = $clog2(HEADER_DEPTH);
    localparam int HEAP_AW = $clog2(HEAP_WORDS);
    localparam int SLOT_W  = $clog2(HEAP_BRICKS);
    localparam int HDR_W   = 33;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MASK = 3'd6;

    localparam logic [1:0] ACT_HDR_WR = 2'd0;
    localparam logic [1:0] ACT_VOX_WR = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OUTSIDE = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_OFFSET,
        ST_RANGE,
        ST_MUL_Z,
        ST_MUL_Y,
        ST_MUL_C,
        ST_HDR_CHK,
        ST_HDR_USE,
        ST_HEAP_RD,
        ST_HEAP_USE,
        ST_DONE
    } t_state;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 6'(v[4*i]) + 6'(v[4*i+1]) + 6'(v[4*i+2]) + 6'(v[4*i+3]);
        end
        return n;
    endfunction

    function automatic logic [9:0] bricks_along(input logic [11:0] extent);
        logic [12:0] s;
        s = 13'(extent) + 13'(BRICK_EDGE - 1);
        return s[12:3];
    endfunction

endpackage

FILE: design/bvl_ram.sv
// ----------------------------------------------------------------------------
// bvl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/brickmap_voxel_lookup.sv
// ----------------------------------------------------------------------------
// brickmap_voxel_lookup
// Sparse brickmap voxel fetch over 8x8x8 bricks with header table and heap.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry an action in s_axis_tuser: header write, voxel write or
//   sample. Writes fill the header table (4096 x 33) or the voxel heap
//   (16 bricks x 512 words) and give no output beat. A sample gives exactly
//   one output beat: voxel value in m_axis_tdata, status in m_axis_tuser.
//   Configuration (origin, extents, channel mask) is written through the
//   i_cfg_* port while no item is in flight.
//   One item at a time: s_axis_tready is high only when the sequencer is idle.
//   A write passes through the write state and returns to ready; a sample
//   outside the region ends after its range check, and one that reads the
//   heap makes three passes through one shared multiply-add unit (brick index
//   and header entry) followed by two dependent registered RAM reads.
//   The result sits in an output register, so a stalled receiver holds only
//   the final step of the next sample, not its acceptance.
//   Synchronous active-low reset clears configuration and control state; the
//   table and heap contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module brickmap_voxel_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bvl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bvl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // coord_x[31:0], coord_y[63:32], coord_z[95:64], chan_sel[100:96],
    // table_index[112:101], voxel_offset[121:113], in_heap[122],
    // data_word[154:123], zero pad[159:155]
    input  logic [159:0]                  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // voxel_value[31:0]
    output logic [31:0]                   m_axis_tdata,
    // status[1:0]
    output logic [1:0]                    m_axis_tuser
);
    import bvl_pkg::*;

    logic [31:0] r_origin_x, r_origin_y, r_origin_z, r_chan_mask;
    logic [11:0] r_extent_x, r_extent_y, r_extent_z;

    t_state r_state, n_state;

    logic [1:0]  r_action;
    logic [31:0] r_cx, r_cy, r_cz, r_word;
    logic [4:0]  r_chan;
    logic [11:0] r_tidx;
    logic [8:0]  r_voff;
    logic        r_loaded;

    logic [31:0] r_xi, r_yi, r_zi;
    logic [4:0]  r_rank;
    logic [5:0]  r_nchan;
    logic [32:0] r_acc;
    logic [HEAP_AW-1:0] r_heap_addr;
    logic [31:0] r_value;
    logic [1:0]  r_status;

    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_status;

    logic        hdr_we, heap_we, load_out;
    logic [HDR_W-1:0] hdr_rdata;
    logic [31:0] heap_rdata;
    logic [9:0]  ex, ey;
    logic        outside;
    logic [26:0] mul_a;
    logic [9:0]  mul_b;
    logic [8:0]  mul_c;
    logic [36:0] mul_full;
    logic [31:0] below_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_origin_z  <= '0;
            r_extent_x  <= '0;
            r_extent_y  <= '0;
            r_extent_z  <= '0;
            r_chan_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_wdata;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_wdata;
                CFG_ORIGIN_Z:  r_origin_z  <= i_cfg_wdata;
                CFG_EXTENT_X:  r_extent_x  <= i_cfg_wdata[11:0];
                CFG_EXTENT_Y:  r_extent_y  <= i_cfg_wdata[11:0];
                CFG_EXTENT_Z:  r_extent_z  <= i_cfg_wdata[11:0];
                CFG_CHAN_MASK: r_chan_mask <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ex = bricks_along(r_extent_x);
    assign ey = bricks_along(r_extent_y);
    assign below_mask = (32'h1 << r_chan) - 32'h1;
    assign outside = (r_xi >= 32'(r_extent_x)) || (r_yi >= 32'(r_extent_y))
                  || (r_zi >= 32'(r_extent_z));

    always_comb begin
        mul_a = r_acc[26:0];
        mul_b = ex;
        mul_c = r_xi[11:3];
        case (r_state)
            ST_MUL_Z: begin
                mul_a = 27'(r_zi[11:3]);
                mul_b = ey;
                mul_c = r_yi[11:3];
            end
            ST_MUL_C: begin
                mul_b = 10'(r_nchan);
                mul_c = 9'(r_rank);
            end
            default: ;
        endcase
    end

    assign mul_full = 37'(mul_a) * 37'(mul_b) + 37'(mul_c);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        ACT_HDR_WR, ACT_VOX_WR: n_state = ST_WRITE;
                        ACT_SAMPLE:             n_state = ST_OFFSET;
                        default:                n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:   n_state = ST_IDLE;
            ST_OFFSET:  n_state = ST_RANGE;
            ST_RANGE:   n_state = outside ? ST_DONE : ST_MUL_Z;
            ST_MUL_Z:   n_state = ST_MUL_Y;
            ST_MUL_Y:   n_state = ST_MUL_C;
            ST_MUL_C:   n_state = ST_HDR_CHK;
            ST_HDR_CHK: n_state = (r_acc >= 33'(HEADER_DEPTH)) ? ST_DONE : ST_HDR_USE;
            ST_HDR_USE: begin
                if (hdr_rdata[32] && hdr_rdata[31:0] < 32'(HEAP_BRICKS)) begin
                    n_state = ST_HEAP_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_HEAP_RD:  n_state = ST_HEAP_USE;
            ST_HEAP_USE: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        hdr_we        = 1'b0;
        heap_we       = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_WRITE: begin
                hdr_we  = (r_action == ACT_HDR_WR) && (32'(r_tidx) < 32'(HEADER_DEPTH));
                heap_we = (r_action == ACT_VOX_WR) && (32'(r_tidx) < 32'(HEAP_BRICKS));
            end
            ST_DONE:  load_out = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_action <= s_axis_tuser;
                r_cx     <= s_axis_tdata[31:0];
                r_cy     <= s_axis_tdata[63:32];
                r_cz     <= s_axis_tdata[95:64];
                r_chan   <= s_axis_tdata[100:96];
                r_tidx   <= s_axis_tdata[112:101];
                r_voff   <= s_axis_tdata[121:113];
                r_loaded <= s_axis_tdata[122];
                r_word   <= s_axis_tdata[154:123];
            end
            ST_OFFSET: begin
                r_xi     <= r_cx - r_origin_x;
                r_yi     <= r_cy - r_origin_y;
                r_zi     <= r_cz - r_origin_z;
                r_rank   <= 5'(popcount32(r_chan_mask & below_mask));
                r_nchan  <= popcount32(r_chan_mask);
                r_value  <= '0;
                r_status <= STAT_OK;
            end
            ST_RANGE: begin
                if (outside) begin
                    r_status <= STAT_OUTSIDE;
                end
            end
            ST_MUL_Z, ST_MUL_Y, ST_MUL_C: begin
                r_acc <= mul_full[32:0];
            end
            ST_HDR_CHK: begin
                if (r_acc >= 33'(HEADER_DEPTH)) begin
                    r_status <= STAT_RANGE;
                end
            end
            ST_HDR_USE: begin
                if (!hdr_rdata[32]) begin
                    r_value <= hdr_rdata[31:0];
                end else if (hdr_rdata[31:0] >= 32'(HEAP_BRICKS)) begin
                    r_status <= STAT_RANGE;
                end
                r_heap_addr <= {hdr_rdata[SLOT_W-1:0], r_zi[2:0], r_yi[2:0], r_xi[2:0]};
            end
            ST_HEAP_USE: begin
                r_value <= heap_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data   <= r_value;
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    bvl_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEADER_DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (HDR_AW'(r_tidx)),
        .i_wdata ({r_loaded, r_word}),
        .i_raddr (r_acc[HDR_AW-1:0]),
        .o_rdata (hdr_rdata)
    );

    bvl_ram #(
        .WIDTH (32),
        .DEPTH (HEAP_WORDS)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr ({r_tidx[SLOT_W-1:0], r_voff}),
        .i_wdata (r_word),
        .i_raddr (r_heap_addr),
        .o_rdata (heap_rdata)
    );

`ifndef ASSERT_OFF
    a_we_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hdr_we && heap_we))
        else $error("header and heap written in the same cycle");

    a_heap_we_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        heap_we |-> (32'(r_tidx) < 32'(HEAP_BRICKS)))
        else $error("heap write beyond store");

    a_load_only_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_action == ACT_SAMPLE))
        else $error("result produced for a write item");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_status != STAT_OK) |=> (m_axis_tdata == 32'd0))
        else $error("error status with nonzero value");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_SAMPLE) |=> !s_axis_tready)
        else $error("new beat taken while sample in flight");
`endif

endmodule
